### rtl/core/rpdc_pkg.sv
// ----------------------------------------------------------------------------
// rpdc_pkg: shared types and constants for the radio packet deframe checker
// Holds field widths, register indexes, verdict codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rpdc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 6;
  localparam int unsigned TypeW  = 3;
  localparam int unsigned LenW   = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [ByteW-1:0]  HeaderReset   = 8'h21;
  localparam logic [ByteW-1:0]  TailReset     = 8'h52;
  localparam logic [CountW-1:0] MinCountReset = 6'd5;
  localparam logic [CountW-1:0] MaxCountReset = 6'd33;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER    = 2'd0,
    CFG_TAIL      = 2'd1,
    CFG_MIN_COUNT = 2'd2,
    CFG_MAX_COUNT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT    = 2'd0,
    VERDICT_FLUSHED   = 2'd1,
    VERDICT_BAD_FRAME = 2'd2,
    VERDICT_BAD_SUM   = 2'd3
  } verdict_t;

endpackage

`default_nettype wire

### rtl/core/radio_packet_deframe_check.sv
// ----------------------------------------------------------------------------
// radio_packet_deframe_check: received payload deframer and checksum check
// Checks header, tail, byte count and inverted-sum checksum of one payload.
// ----------------------------------------------------------------------------
// The verdict appears in the output register in the cycle after the final byte
// is accepted. Bytes go in at one per cycle, but a final byte stalls while a
// verdict waits; counter, sum and previous byte update in one registered step.
// Reset (rst_n low, synchronous): configuration returns to header 0x21,
// tail 0x52, count range 5..33; packet state and output valid clear.
`default_nettype none

module radio_packet_deframe_check (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input byte channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rpdc_pkg::ByteW-1:0]    in_data_byte,
  input  wire logic                          in_last_byte,
  // verdict channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_verdict,
  output logic [rpdc_pkg::TypeW-1:0]         out_packet_type,
  output logic [rpdc_pkg::LenW-1:0]          out_payload_length,
  output logic [rpdc_pkg::CountW-1:0]        out_byte_count,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rpdc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [rpdc_pkg::ByteW-1:0]    cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rpdc_pkg::ByteW-1:0]  header_r;
  logic [rpdc_pkg::ByteW-1:0]  tail_r;
  logic [rpdc_pkg::CountW-1:0] min_count_r;
  logic [rpdc_pkg::CountW-1:0] max_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r    <= rpdc_pkg::HeaderReset;
      tail_r      <= rpdc_pkg::TailReset;
      min_count_r <= rpdc_pkg::MinCountReset;
      max_count_r <= rpdc_pkg::MaxCountReset;
    end else if (cfg_valid && cfg_ready) begin
      case (rpdc_pkg::cfg_idx_t'(cfg_index))
        rpdc_pkg::CFG_HEADER:    header_r    <= cfg_data;
        rpdc_pkg::CFG_TAIL:      tail_r      <= cfg_data;
        rpdc_pkg::CFG_MIN_COUNT: min_count_r <= cfg_data[rpdc_pkg::CountW-1:0];
        rpdc_pkg::CFG_MAX_COUNT: max_count_r <= cfg_data[rpdc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  // Middle bytes produce no verdict, so keep taking them even while a
  // verdict waits downstream; hold only a final byte that would need the
  // occupied output register.
  logic out_valid_r;
  logic in_accept;
  logic out_take;

  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = out_valid_r && out_stall && in_last_byte;
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Per-packet state
  // --------------------------------------------------------------------------
  logic [rpdc_pkg::CountW-1:0] byte_idx_r,  byte_idx_nxt;
  logic                        hdr_ok_r,    hdr_ok_nxt;
  logic [rpdc_pkg::ByteW-1:0]  sum_r,       sum_nxt;
  logic [rpdc_pkg::ByteW-1:0]  prev_byte_r;
  logic [rpdc_pkg::LenW-1:0]   len_r,       len_nxt;
  logic [rpdc_pkg::TypeW-1:0]  type_r,      type_nxt;

  logic [rpdc_pkg::CountW-1:0] count;
  logic [rpdc_pkg::CountW-1:0] sum_limit;
  logic [1:0]                  verdict;

  // Bytes past the header and type/length byte are summed up to position
  // length+1; positions that never arrive simply contribute nothing.
  assign count     = (byte_idx_r == rpdc_pkg::CountMax) ? rpdc_pkg::CountMax
                                                        : byte_idx_r + 1'b1;
  assign sum_limit = rpdc_pkg::CountW'(len_r) + 1'b1;

  always_comb begin
    hdr_ok_nxt = hdr_ok_r;
    len_nxt    = len_r;
    type_nxt   = type_r;
    sum_nxt    = sum_r;
    if (byte_idx_r == '0) begin
      hdr_ok_nxt = (in_data_byte == header_r);
    end else if (byte_idx_r == rpdc_pkg::CountW'(1)) begin
      len_nxt  = in_data_byte[rpdc_pkg::LenW-1:0];
      type_nxt = in_data_byte[rpdc_pkg::ByteW-1 -: rpdc_pkg::TypeW];
    end else if (byte_idx_r <= sum_limit) begin
      sum_nxt = sum_r + in_data_byte;
    end
    byte_idx_nxt = count;
  end

  // Count range first, then frame markers, then the checksum, which is the
  // inverted sum against the byte just before the tail.
  always_comb begin
    if (count < min_count_r || count > max_count_r) begin
      verdict = rpdc_pkg::VERDICT_FLUSHED;
    end else if (!hdr_ok_nxt || in_data_byte != tail_r) begin
      verdict = rpdc_pkg::VERDICT_BAD_FRAME;
    end else if (~sum_nxt != prev_byte_r) begin
      verdict = rpdc_pkg::VERDICT_BAD_SUM;
    end else begin
      verdict = rpdc_pkg::VERDICT_ACCEPT;
    end
  end

  // Advance on every accepted byte; drop back to a clean packet after the
  // final byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r  <= '0;
      hdr_ok_r    <= 1'b0;
      sum_r       <= '0;
      prev_byte_r <= '0;
      len_r       <= '0;
      type_r      <= '0;
    end else if (in_accept) begin
      if (in_last_byte) begin
        byte_idx_r  <= '0;
        hdr_ok_r    <= 1'b0;
        sum_r       <= '0;
        prev_byte_r <= '0;
        len_r       <= '0;
        type_r      <= '0;
      end else begin
        byte_idx_r  <= byte_idx_nxt;
        hdr_ok_r    <= hdr_ok_nxt;
        sum_r       <= sum_nxt;
        prev_byte_r <= in_data_byte;
        len_r       <= len_nxt;
        type_r      <= type_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic out_load;
  assign out_load = in_accept && in_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [1:0]                  verdict_r;
  logic [rpdc_pkg::TypeW-1:0]  out_type_r;
  logic [rpdc_pkg::LenW-1:0]   out_len_r;
  logic [rpdc_pkg::CountW-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict_r   <= verdict;
      out_type_r  <= type_nxt;
      out_len_r   <= len_nxt;
      out_count_r <= count;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_verdict        = verdict_r;
  assign out_packet_type    = out_type_r;
  assign out_payload_length = out_len_r;
  assign out_byte_count     = out_count_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A final byte always returns the packet state to its start.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_last_byte) |=> (byte_idx_r == '0 && sum_r == '0 && !hdr_ok_r))
    else $error("packet state not cleared after final byte");

  // A verdict only shows up because a final byte was taken.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept && in_last_byte))
    else $error("verdict raised without a final byte");

  // An accepted packet must have a count inside the configured range.
  a_accept_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && verdict_r == rpdc_pkg::VERDICT_ACCEPT) |->
      (out_count_r >= min_count_r && out_count_r <= max_count_r))
    else $error("accepted verdict with count out of range");

  // A waiting verdict is never overwritten by another final byte.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("verdict overwritten while stalled");

endmodule

`default_nettype wire
